### design/complex_integer_alu_defines.svh
// Assertion macros used by the complex integer ALU top level.
`ifndef COMPLEX_INTEGER_ALU_DEFINES_SVH
`define COMPLEX_INTEGER_ALU_DEFINES_SVH
`ifndef ASSERT_OFF
`define CIA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define CIA_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define CIA_ASSERT(label, clk, rst, prop)
`define CIA_NEVER(label, clk, rst, cond)
`endif
`endif

### design/cia_pkg.sv
// Shared types and constants of the complex integer ALU.
package cia_pkg;
   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int RES_WIDTH = 33;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // control that travels with an item down the divider row
   typedef struct packed {
      logic valid;
      logic bypass;
      logic neg_re;
      logic neg_im;
      logic flag;
   } ctl_type;
endpackage

### design/cia_front.sv
// Operand register, products and sign-magnitude sums feeding the divider row.
module cia_front
   import cia_pkg::*;
#(
   parameter int W = OPERAND_WIDTH_DEF,
   parameter int MW = 2 * W + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                acc,
   input  logic [1:0]          kind,
   input  logic signed [W-1:0] a_real,
   input  logic signed [W-1:0] a_imag,
   input  logic signed [W-1:0] b_real,
   input  logic signed [W-1:0] b_imag,
   output ctl_type             ctl_out,
   output logic [MW-1:0]       mag_re,
   output logic [MW-1:0]       mag_im,
   output logic [MW-1:0]       den
);
   localparam int SW = 2 * W + 2;

   // stage A: operands and products
   logic                  va_ff;
   op_type                kind_ff;
   logic signed [W-1:0]   ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [2*W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= acc;
      end
      kind_ff <= op_type'(kind);
      ar_ff   <= a_real;
      ai_ff   <= a_imag;
      br_ff   <= b_real;
      bi_ff   <= b_imag;
      p_rr_ff <= (2*W)'(a_real) * (2*W)'(b_real);
      p_ii_ff <= (2*W)'(a_imag) * (2*W)'(b_imag);
      p_ri_ff <= (2*W)'(a_real) * (2*W)'(b_imag);
      p_ir_ff <= (2*W)'(a_imag) * (2*W)'(b_real);
      p_bb_ff <= (2*W)'(b_real) * (2*W)'(b_real);
      p_cc_ff <= (2*W)'(b_imag) * (2*W)'(b_imag);
   end

   // stage B: combine parts, take magnitudes
   logic signed [SW-1:0] re_v, im_v, re_a, im_a;
   logic [MW-1:0]        den_in;
   ctl_type              ctl_in;
   logic [MW-1:0]        mre_in, mim_in;

   always_comb begin
      den_in = MW'($unsigned(p_bb_ff)) + MW'($unsigned(p_cc_ff));
      case (kind_ff)
         OP_ADD: begin
            re_v = SW'(ar_ff) + SW'(br_ff);
            im_v = SW'(ai_ff) + SW'(bi_ff);
         end
         OP_SUB: begin
            re_v = SW'(ar_ff) - SW'(br_ff);
            im_v = SW'(ai_ff) - SW'(bi_ff);
         end
         OP_MUL: begin
            re_v = SW'(p_rr_ff) - SW'(p_ii_ff);
            im_v = SW'(p_ri_ff) + SW'(p_ir_ff);
         end
         default: begin
            re_v = SW'(p_rr_ff) + SW'(p_ii_ff);
            im_v = SW'(p_ir_ff) - SW'(p_ri_ff);
         end
      endcase
      re_a = re_v[SW-1] ? -re_v : re_v;
      im_a = im_v[SW-1] ? -im_v : im_v;
      ctl_in.valid  = va_ff;
      ctl_in.bypass = 1'b1;
      ctl_in.flag   = 1'b0;
      ctl_in.neg_re = re_v[SW-1];
      ctl_in.neg_im = im_v[SW-1];
      mre_in = re_a[MW-1:0];
      mim_in = im_a[MW-1:0];
      if (kind_ff == OP_DIV) begin
         if (den_in == '0) begin
            ctl_in.flag   = 1'b1;
            ctl_in.neg_re = 1'b0;
            ctl_in.neg_im = 1'b0;
            mre_in = '0;
            mim_in = '0;
         end else begin
            ctl_in.bypass = 1'b0;
         end
      end
   end

   ctl_type       ctl_ff;
   logic [MW-1:0] mre_ff, mim_ff, den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      mre_ff <= mre_in;
      mim_ff <= mim_in;
      den_ff <= den_in;
   end

   assign ctl_out = ctl_ff;
   assign mag_re  = mre_ff;
   assign mag_im  = mim_ff;
   assign den     = den_ff;
endmodule

### design/cia_div_cell.sv
// One restoring-division cell: yields one quotient bit of each part per division item; others pass through.
module cia_div_cell
   import cia_pkg::*;
#(
   parameter int MW = 2 * OPERAND_WIDTH_DEF + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_type       ctl_i,
   input  logic [MW-1:0] rem_re_i,
   input  logic [MW-1:0] num_re_i,
   input  logic [MW-1:0] rem_im_i,
   input  logic [MW-1:0] num_im_i,
   input  logic [MW-1:0] den_i,
   output ctl_type       ctl_o,
   output logic [MW-1:0] rem_re_o,
   output logic [MW-1:0] num_re_o,
   output logic [MW-1:0] rem_im_o,
   output logic [MW-1:0] num_im_o,
   output logic [MW-1:0] den_o
);
   ctl_type       ctl_ff;
   logic [MW-1:0] rre_ff, nre_ff, rim_ff, nim_ff, den_ff;
   logic [MW-1:0] rre_in, nre_in, rim_in, nim_in;
   logic [MW:0]   t_re, t_im;

   // shift in the next numerator bit, subtract the divisor when it fits
   always_comb begin
      t_re = {rem_re_i, num_re_i[MW-1]};
      t_im = {rem_im_i, num_im_i[MW-1]};
      rre_in = rem_re_i;
      nre_in = num_re_i;
      rim_in = rem_im_i;
      nim_in = num_im_i;
      if (!ctl_i.bypass) begin
         if (t_re >= {1'b0, den_i}) begin
            rre_in = MW'(t_re - {1'b0, den_i});
            nre_in = {num_re_i[MW-2:0], 1'b1};
         end else begin
            rre_in = t_re[MW-1:0];
            nre_in = {num_re_i[MW-2:0], 1'b0};
         end
         if (t_im >= {1'b0, den_i}) begin
            rim_in = MW'(t_im - {1'b0, den_i});
            nim_in = {num_im_i[MW-2:0], 1'b1};
         end else begin
            rim_in = t_im[MW-1:0];
            nim_in = {num_im_i[MW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      rre_ff <= rre_in;
      nre_ff <= nre_in;
      rim_ff <= rim_in;
      nim_ff <= nim_in;
      den_ff <= den_i;
   end

   assign ctl_o    = ctl_ff;
   assign rem_re_o = rre_ff;
   assign num_re_o = nre_ff;
   assign rem_im_o = rim_ff;
   assign num_im_o = nim_ff;
   assign den_o    = den_ff;
endmodule

### design/complex_integer_alu.sv
// Top level of the complex integer ALU: front stages, divider row, output register.
//
//  channel  ports                       handshake
//  request  req_kind, req_a_*, req_b_*  start & !busy
//  result   rsp_res_*, rsp_div_by_zero  rsp_valid, one cycle, no stall
//
// One item per cycle is accepted; busy is held low.
// Each item passes through two front stages, one divider cell per
// numerator bit (2*OPERAND_WIDTH+1), and the output register.
// Every operation walks the whole row so results leave in order.
// Synchronous reset clears all valid flags; the receiver cannot stall.
`include "complex_integer_alu_defines.svh"
module complex_integer_alu
   import cia_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_kind,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_real,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_imag,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_real,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_imag,
   output logic                            rsp_valid,
   output logic signed [RES_WIDTH-1:0]     rsp_res_real,
   output logic signed [RES_WIDTH-1:0]     rsp_res_imag,
   output logic                            rsp_div_by_zero
);
   localparam int MW  = 2 * OPERAND_WIDTH + 1;
   localparam int XW  = (MW + 1 > RES_WIDTH) ? MW + 1 : RES_WIDTH;
   localparam int LAT = MW + 3;

   assign busy = 1'b0;

   ctl_type       ctl [MW+1];
   logic [MW-1:0] rre [MW+1];
   logic [MW-1:0] nre [MW+1];
   logic [MW-1:0] rim [MW+1];
   logic [MW-1:0] nim [MW+1];
   logic [MW-1:0] dn  [MW+1];

   cia_front #(.W(OPERAND_WIDTH), .MW(MW)) u_front (
      .clock   (clock),
      .reset   (reset),
      .acc     (start & ~busy),
      .kind    (req_kind),
      .a_real  (req_a_real),
      .a_imag  (req_a_imag),
      .b_real  (req_b_real),
      .b_imag  (req_b_imag),
      .ctl_out (ctl[0]),
      .mag_re  (nre[0]),
      .mag_im  (nim[0]),
      .den     (dn[0])
   );
   assign rre[0] = '0;
   assign rim[0] = '0;

   // divider row, one quotient bit per cell
   for (genvar i = 0; i < MW; i++) begin : g_cell
      cia_div_cell #(.MW(MW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_i    (ctl[i]),
         .rem_re_i (rre[i]),
         .num_re_i (nre[i]),
         .rem_im_i (rim[i]),
         .num_im_i (nim[i]),
         .den_i    (dn[i]),
         .ctl_o    (ctl[i+1]),
         .rem_re_o (rre[i+1]),
         .num_re_o (nre[i+1]),
         .rem_im_o (rim[i+1]),
         .num_im_o (nim[i+1]),
         .den_o    (dn[i+1])
      );
   end

   // restore signs and fit to the result width
   logic signed [MW:0]          sre, sim;
   logic signed [XW-1:0]        xre, xim;
   logic                        val_ff, flag_ff;
   logic signed [RES_WIDTH-1:0] re_ff, im_ff;

   always_comb begin
      sre = ctl[MW].neg_re ? -$signed({1'b0, nre[MW]}) : $signed({1'b0, nre[MW]});
      sim = ctl[MW].neg_im ? -$signed({1'b0, nim[MW]}) : $signed({1'b0, nim[MW]});
      xre = XW'(sre);
      xim = XW'(sim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= 1'b0;
      end else begin
         val_ff <= ctl[MW].valid;
      end
      flag_ff <= ctl[MW].flag;
      re_ff   <= xre[RES_WIDTH-1:0];
      im_ff   <= xim[RES_WIDTH-1:0];
   end

   assign rsp_valid       = val_ff;
   assign rsp_res_real    = re_ff;
   assign rsp_res_imag    = im_ff;
   assign rsp_div_by_zero = val_ff & flag_ff;

   `CIA_NEVER(a_never_busy, clock, reset, busy)
   `CIA_ASSERT(a_valid_from_start, clock, reset, rsp_valid |-> $past(start && !reset, LAT))
   `CIA_NEVER(a_flag_zero_re, clock, reset, rsp_div_by_zero && (rsp_res_real != '0))
   `CIA_NEVER(a_flag_zero_im, clock, reset, rsp_div_by_zero && (rsp_res_imag != '0))
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the complex integer ALU: random and directed items, in-order checks.
module testbench
   import cia_pkg::*;
();

   localparam int W = OPERAND_WIDTH_DEF;
   localparam int LATENCY = 2 * W + 4;

   typedef struct {
      op_type              kind;
      logic signed [W-1:0] ar, ai, br, bi;
   } alu_item_type;

   typedef struct {
      logic signed [RES_WIDTH-1:0] re, im;
      logic                        dz;
   } alu_result_type;

   logic clock = 0, reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_kind = '0;
   logic signed [W-1:0] req_a_real = '0, req_a_imag = '0, req_b_real = '0, req_b_imag = '0;
   logic rsp_valid;
   logic signed [RES_WIDTH-1:0] rsp_res_real, rsp_res_imag;
   logic rsp_div_by_zero;

   alu_item_type   pending_items[$];
   alu_result_type expected_results[$];
   int             idle_pct = 0;
   int             fail_count = 0;
   int             checked_count = 0;
   bit             stim_done = 0;

   complex_integer_alu i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_a_real(req_a_real), .req_a_imag(req_a_imag),
      .req_b_real(req_b_real), .req_b_imag(req_b_imag),
      .rsp_valid(rsp_valid), .rsp_res_real(rsp_res_real),
      .rsp_res_imag(rsp_res_imag), .rsp_div_by_zero(rsp_div_by_zero)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // exact complex arithmetic in 64 bits, quotient truncated toward zero
   function automatic alu_result_type compute_result(alu_item_type it);
      alu_result_type r;
      longint ar, ai, br, bi, den, nre, nim;
      ar = longint'(it.ar); ai = longint'(it.ai);
      br = longint'(it.br); bi = longint'(it.bi);
      r.dz = 0;
      nre = 0; nim = 0;
      case (it.kind)
         OP_ADD: begin nre = ar + br; nim = ai + bi; end
         OP_SUB: begin nre = ar - br; nim = ai - bi; end
         OP_MUL: begin nre = ar * br - ai * bi; nim = ar * bi + ai * br; end
         OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.dz = 1;
            end else begin
               nre = (ar * br + ai * bi) / den;
               nim = (ai * br - ar * bi) / den;
            end
         end
         default: r.dz = 0;
      endcase
      r.re = nre[RES_WIDTH-1:0];
      r.im = nim[RES_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic signed [W-1:0] pick_part();
      case ($urandom_range(0, 5))
         0: return {1'b1, {(W-1){1'b0}}};
         1: return {1'b0, {(W-1){1'b1}}};
         2: return W'($urandom_range(0, 6) - 3);
         default: return W'($urandom);
      endcase
   endfunction

   task automatic queue_item(op_type k, logic signed [W-1:0] ar, ai, br, bi);
      alu_item_type it;
      it.kind = k; it.ar = ar; it.ai = ai; it.br = br; it.bi = bi;
      pending_items.push_back(it);
   endtask

   // driver: present next item, hold while busy
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (start && busy) begin
         start <= 1;
      end else if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
         alu_item_type it;
         it = pending_items.pop_front();
         expected_results.push_back(compute_result(it));
         start <= 1;
         req_kind <= it.kind;
         req_a_real <= it.ar; req_a_imag <= it.ai;
         req_b_real <= it.br; req_b_imag <= it.bi;
      end else begin
         start <= 0;
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result with no expectation: re=%0d im=%0d", rsp_res_real, rsp_res_imag);
            fail_count++;
         end else begin
            alu_result_type e;
            e = expected_results.pop_front();
            checked_count++;
            if (rsp_res_real !== e.re) begin
               $error("res_real expected %0d actual %0d", e.re, rsp_res_real);
               fail_count++;
            end
            if (rsp_res_imag !== e.im) begin
               $error("res_imag expected %0d actual %0d", e.im, rsp_res_imag);
               fail_count++;
            end
            if (rsp_div_by_zero !== e.dz) begin
               $error("div_by_zero expected %0d actual %0d", e.dz, rsp_div_by_zero);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic signed [W-1:0] mn, mx;
      int phase, n;
      mn = {1'b1, {(W-1){1'b0}}};
      mx = {1'b0, {(W-1){1'b1}}};
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed: extremes, each op, zero denominator
      for (int k = 0; k < 4; k++) begin
         queue_item(op_type'(k), mn, mn, mn, mn);
         queue_item(op_type'(k), mx, mx, mx, mx);
         queue_item(op_type'(k), mn, mx, mx, mn);
         queue_item(op_type'(k), W'(0), W'(0), W'(0), W'(0));
         queue_item(op_type'(k), mx, mn, W'(1), W'(-1));
      end
      queue_item(OP_DIV, W'(5), W'(-7), W'(0), W'(0));
      queue_item(OP_DIV, W'(-7), W'(5), W'(2), W'(0));
      queue_item(OP_DIV, W'(1), W'(1), W'(0), W'(1));
      // random phases with varying sender idling
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: idle_pct = 0;
            1: idle_pct = 45;
            2: idle_pct = 13;
            default: idle_pct = 0;
         endcase
         for (n = 0; n < 125; n++) begin
            if ($urandom_range(0, 9) == 0)
               queue_item(OP_DIV, pick_part(), pick_part(), W'(0), W'(0));
            else
               queue_item(op_type'($urandom_range(0, 3)), pick_part(), pick_part(),
                          pick_part(), pick_part());
         end
         while (pending_items.size() > 0) @(posedge clock);
      end
      while (expected_results.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      stim_done = 1;
   end

   // final report
   initial begin
      wait (stim_done);
      $display("covered %0d results over all four operations incl. zero divisors", checked_count);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("tb: failure");
      $finish;
   end
endmodule
